// ===== rtl/core/ws2812_pkg.sv =====
// Package for the WS2812 pixel serializer: payload structs, register
// indexes, register reset values and frame limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ws2812_pkg;

	localparam int unsigned MAX_PIXELS    = 1024;
	localparam int unsigned POSITION_SPAN = 1024;
	localparam int unsigned BITS_PER_PIXEL = 24;

	localparam int unsigned HIGH_W  = 10;
	localparam int unsigned LOW_W   = 20;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned CFG_W   = 20;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned SYM_W   = 5;

	// register indexes of the configuration port
	localparam logic [INDEX_W-1:0] REG_ZERO_HIGH  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_ONE_HIGH   = 3'd1;
	localparam logic [INDEX_W-1:0] REG_BIT_PERIOD = 3'd2;
	localparam logic [INDEX_W-1:0] REG_LATCH      = 3'd3;
	localparam logic [INDEX_W-1:0] REG_PIXEL_CNT  = 3'd4;
	localparam logic [INDEX_W-1:0] REG_FAULTY_A   = 3'd5;
	localparam logic [INDEX_W-1:0] REG_FAULTY_B   = 3'd6;

	localparam logic [HIGH_W-1:0]  RST_ZERO_HIGH  = 10'd168;
	localparam logic [HIGH_W-1:0]  RST_ONE_HIGH   = 10'd360;
	localparam logic [HIGH_W-1:0]  RST_BIT_PERIOD = 10'd600;
	localparam logic [LOW_W-1:0]   RST_LATCH      = 20'd960000;
	localparam logic [COUNT_W-1:0] RST_PIXEL_CNT  = 11'd640;
	localparam logic [POS_W-1:0]   RST_FAULTY_A   = 10'd136;
	localparam logic [POS_W-1:0]   RST_FAULTY_B   = 10'd195;

	typedef struct packed {
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
	} pixel_t;

	typedef struct packed {
		logic              bit_value;
		logic [HIGH_W-1:0] high_time;
		logic [LOW_W-1:0]  low_time;
		logic              is_latch;
		logic              last_symbol;
	} symbol_t;

endpackage

`default_nettype wire

// ===== rtl/core/ws2812_pixel_serializer.sv =====
// WS2812 pixel serializer: one pixel in gives 24 bit symbols out, GRB, MSB first,
// plus a latch symbol after the last pixel of a frame. Uses ws2812_pkg.
//
// A pixel is accepted into a holding register, then, while the output does not
// stall, one symbol per cycle is written to an output register: the 24 bit symbols,
// plus the latch symbol when the pixel ends a frame, as counted by the symbol
// counter over the holding register. The next pixel is accepted in the cycle that
// the final symbol of the current one leaves the holding stage, so a continuous
// stream runs with no gap; output stalls hold the output register and pause the
// counter. Positions in the two faulty registers are sent black. The user writes
// registers through the cfg port only while the block is idle; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module ws2812_pixel_serializer
	import ws2812_pkg::*;
#(
	parameter int unsigned FRAME_MAX = MAX_PIXELS
)
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [INDEX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                pixel_valid,
	output      logic                pixel_ready,
	input  wire pixel_t              pixel,
	output      logic                symbol_valid,
	input  wire logic                symbol_ready,
	output      symbol_t             symbol
);

	localparam int unsigned FRAME_CAP =
		(FRAME_MAX < POSITION_SPAN) ? FRAME_MAX : POSITION_SPAN;
	localparam logic [COUNT_W-1:0] FRAME_CAP_C = COUNT_W'(FRAME_CAP);
	localparam logic [SYM_W-1:0]   LAST_BIT    = SYM_W'(BITS_PER_PIXEL - 1);
	localparam logic [SYM_W-1:0]   LATCH_SYM   = SYM_W'(BITS_PER_PIXEL);

	logic [HIGH_W-1:0]  zero_high_q;
	logic [HIGH_W-1:0]  one_high_q;
	logic [HIGH_W-1:0]  bit_period_q;
	logic [LOW_W-1:0]   latch_q;
	logic [COUNT_W-1:0] pixel_cnt_q;
	logic [POS_W-1:0]   faulty_a_q;
	logic [POS_W-1:0]   faulty_b_q;
	logic [POS_W-1:0]   pos_q;

	logic                      valid_s1;
	logic [BITS_PER_PIXEL-1:0] word_s1;
	logic                      eof_s1;
	logic [SYM_W-1:0]          sym_cnt_q;

	logic                      accept;
	logic                      emit;
	logic                      done;
	logic [COUNT_W-1:0]        frame_len;
	logic [COUNT_W-1:0]        pos_next;
	logic                      eof_in;
	logic                      black;
	logic [BITS_PER_PIXEL-1:0] word_in;
	logic                      cur_bit;
	logic [HIGH_W-1:0]         cur_high;
	logic [HIGH_W-1:0]         cur_low;
	logic                      is_latch_sym;
	symbol_t                   sym_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q  <= RST_ZERO_HIGH;
			one_high_q   <= RST_ONE_HIGH;
			bit_period_q <= RST_BIT_PERIOD;
			latch_q      <= RST_LATCH;
			pixel_cnt_q  <= RST_PIXEL_CNT;
			faulty_a_q   <= RST_FAULTY_A;
			faulty_b_q   <= RST_FAULTY_B;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_HIGH:  zero_high_q  <= cfg_data[HIGH_W-1:0];
				REG_ONE_HIGH:   one_high_q   <= cfg_data[HIGH_W-1:0];
				REG_BIT_PERIOD: bit_period_q <= cfg_data[HIGH_W-1:0];
				REG_LATCH:      latch_q      <= cfg_data[LOW_W-1:0];
				REG_PIXEL_CNT:  pixel_cnt_q  <= cfg_data[COUNT_W-1:0];
				REG_FAULTY_A:   faulty_a_q   <= cfg_data[POS_W-1:0];
				REG_FAULTY_B:   faulty_b_q   <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// frame length: zero acts as one, clamp to FRAME_MAX and the position span
	always_comb begin
		frame_len = pixel_cnt_q;
		if (frame_len == '0) begin
			frame_len = COUNT_W'(1);
		end
		if (frame_len > FRAME_CAP_C) begin
			frame_len = FRAME_CAP_C;
		end
	end

	assign pos_next = {1'b0, pos_q} + COUNT_W'(1);
	assign eof_in   = (pos_next >= frame_len);
	assign black    = (pos_q == faulty_a_q) || (pos_q == faulty_b_q);
	assign word_in  = black ? '0 : {pixel.green_level, pixel.red_level, pixel.blue_level};

	assign emit  = valid_s1 && (!symbol_valid || symbol_ready);
	assign done  = emit && ((sym_cnt_q == LAST_BIT && !eof_s1) || sym_cnt_q == LATCH_SYM);
	assign pixel_ready = !valid_s1 || done;
	assign accept      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= eof_in ? '0 : pos_next[POS_W-1:0];
		end
	end

	// holding stage: shift the pixel word out MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			sym_cnt_q <= '0;
		end else if (accept) begin
			valid_s1  <= 1'b1;
			sym_cnt_q <= '0;
		end else if (done) begin
			valid_s1  <= 1'b0;
		end else if (emit) begin
			sym_cnt_q <= sym_cnt_q + SYM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= word_in;
			eof_s1  <= eof_in;
		end else if (emit) begin
			word_s1 <= {word_s1[BITS_PER_PIXEL-2:0], 1'b0};
		end
	end

	assign is_latch_sym = (sym_cnt_q == LATCH_SYM);
	assign cur_bit      = word_s1[BITS_PER_PIXEL-1];
	assign cur_high     = cur_bit ? one_high_q : zero_high_q;
	assign cur_low      = (bit_period_q > cur_high) ? (bit_period_q - cur_high) : '0;

	always_comb begin
		if (is_latch_sym) begin
			sym_next.bit_value   = 1'b0;
			sym_next.high_time   = '0;
			sym_next.low_time    = latch_q;
			sym_next.is_latch    = 1'b1;
			sym_next.last_symbol = 1'b1;
		end else begin
			sym_next.bit_value   = cur_bit;
			sym_next.high_time   = cur_high;
			sym_next.low_time    = {{(LOW_W-HIGH_W){1'b0}}, cur_low};
			sym_next.is_latch    = 1'b0;
			sym_next.last_symbol = (sym_cnt_q == LAST_BIT) && !eof_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_valid <= 1'b0;
		end else if (emit) begin
			symbol_valid <= 1'b1;
		end else if (symbol_ready) begin
			symbol_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol <= sym_next;
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (sym_cnt_q <= LATCH_SYM))
		else $error("symbol counter past latch slot");

	a_latch_only_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_latch_sym) |-> eof_s1)
		else $error("latch slot reached on a pixel that does not end the frame");

	a_accept_slot: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!valid_s1 || done))
		else $error("pixel item accepted over a busy holding stage");

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eof_in) |=> (pos_q == '0))
		else $error("pixel position did not restart after frame end");

	a_latch_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(symbol_valid && symbol.is_latch) |-> (symbol.last_symbol && symbol.high_time == '0))
		else $error("latch symbol fields wrong");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the WS2812 pixel serializer: directed and random pixels,
// configuration phases and a symbol predictor with an in-order scoreboard.
// Depends on ws2812_pkg and ws2812_pixel_serializer.
`timescale 1ns / 1ps

module testbench;
	import ws2812_pkg::*;

	localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 50;

	class symbol_scoreboard;
		logic [HIGH_W-1:0]  zero_high;
		logic [HIGH_W-1:0]  one_high;
		logic [HIGH_W-1:0]  bit_period;
		logic [LOW_W-1:0]   latch_len;
		logic [COUNT_W-1:0] pixel_cnt;
		logic [POS_W-1:0]   faulty_a;
		logic [POS_W-1:0]   faulty_b;
		logic [POS_W-1:0]   position;
		symbol_t            expected_symbols[$];
		int                 errors;

		function new();
			zero_high  = RST_ZERO_HIGH;
			one_high   = RST_ONE_HIGH;
			bit_period = RST_BIT_PERIOD;
			latch_len  = RST_LATCH;
			pixel_cnt  = RST_PIXEL_CNT;
			faulty_a   = RST_FAULTY_A;
			faulty_b   = RST_FAULTY_B;
			position   = '0;
			errors     = 0;
		endfunction

		function void set_register(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ZERO_HIGH:  zero_high  = data[HIGH_W-1:0];
				REG_ONE_HIGH:   one_high   = data[HIGH_W-1:0];
				REG_BIT_PERIOD: bit_period = data[HIGH_W-1:0];
				REG_LATCH:      latch_len  = data[LOW_W-1:0];
				REG_PIXEL_CNT:  pixel_cnt  = data[COUNT_W-1:0];
				REG_FAULTY_A:   faulty_a   = data[POS_W-1:0];
				REG_FAULTY_B:   faulty_b   = data[POS_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned frame_length();
			int unsigned n;
			n = 32'(pixel_cnt);
			if (n == 0)
				n = 1;
			if (n > MAX_PIXELS)
				n = MAX_PIXELS;
			if (n > POSITION_SPAN)
				n = POSITION_SPAN;
			return n;
		endfunction

		function void note_pixel(pixel_t p);
			logic [BITS_PER_PIXEL-1:0] word;
			logic                      end_of_frame;
			symbol_t                   s;
			end_of_frame = (int'(position) + 1 >= int'(frame_length()));
			// blacked-out positions send all zero bits
			if (position == faulty_a || position == faulty_b)
				word = '0;
			else
				word = {p.green_level, p.red_level, p.blue_level};
			for (int k = 0; k < BITS_PER_PIXEL; k++) begin
				s.bit_value   = word[BITS_PER_PIXEL-1-k];
				s.high_time   = s.bit_value ? one_high : zero_high;
				s.low_time    = (bit_period > s.high_time) ?
					LOW_W'(bit_period - s.high_time) : '0;
				s.is_latch    = 1'b0;
				s.last_symbol = (k == BITS_PER_PIXEL - 1) && !end_of_frame;
				expected_symbols.push_back(s);
			end
			if (end_of_frame) begin
				s.bit_value   = 1'b0;
				s.high_time   = '0;
				s.low_time    = latch_len;
				s.is_latch    = 1'b1;
				s.last_symbol = 1'b1;
				expected_symbols.push_back(s);
				position = '0;
			end else begin
				position = position + 1'b1;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check(symbol_t got);
			symbol_t want;
			if (expected_symbols.size() == 0) begin
				$display("%0t: symbol with no pixel behind it, expected none actual %h",
					$time, got);
				errors++;
				return;
			end
			want = expected_symbols.pop_front();
			compare_field("bit_value", 32'(want.bit_value), 32'(got.bit_value));
			compare_field("high_time", 32'(want.high_time), 32'(got.high_time));
			compare_field("low_time", 32'(want.low_time), 32'(got.low_time));
			compare_field("is_latch", 32'(want.is_latch), 32'(got.is_latch));
			compare_field("last_symbol", 32'(want.last_symbol), 32'(got.last_symbol));
		endfunction

		function int pending();
			return expected_symbols.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               pixel_valid;
	logic               pixel_ready;
	pixel_t             pixel;
	logic               symbol_valid;
	logic               symbol_ready;
	symbol_t            symbol;

	symbol_scoreboard   sb;
	bit                 sender_idle_on;
	bit                 receiver_idle_on;
	int                 hold_request;

	ws2812_pixel_serializer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.symbol_valid (symbol_valid),
		.symbol_ready (symbol_ready),
		.symbol       (symbol)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int pick_gap(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function logic [CFG_W-1:0] pick_value(int unsigned max_value);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return CFG_W'(max_value);
			default: return CFG_W'($urandom_range(0, max_value));
		endcase
	endfunction

	function logic [CFG_W-1:0] pick_faulty(int unsigned frame_len);
		case ($urandom_range(0, 2))
			0: return CFG_W'($urandom_range(0, frame_len - 1));
			1: return CFG_W'((sb.position + $urandom_range(0, 5)) % POSITION_SPAN);
			default: return CFG_W'($urandom_range(0, POSITION_SPAN - 1));
		endcase
	endfunction

	task write_register(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task apply_config(input logic [CFG_W-1:0] zh, input logic [CFG_W-1:0] oh,
			input logic [CFG_W-1:0] bp, input logic [CFG_W-1:0] lt,
			input logic [CFG_W-1:0] pc, input logic [CFG_W-1:0] fa,
			input logic [CFG_W-1:0] fb);
		write_register(REG_ZERO_HIGH, zh);
		write_register(REG_ONE_HIGH, oh);
		write_register(REG_BIT_PERIOD, bp);
		write_register(REG_LATCH, lt);
		write_register(REG_PIXEL_CNT, pc);
		write_register(REG_FAULTY_A, fa);
		write_register(REG_FAULTY_B, fb);
	endtask

	task send_pixel(input pixel_t p);
		int gap;
		gap = pick_gap(sender_idle_on);
		@(negedge clk);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		do @(posedge clk); while (!pixel_ready);
		sb.note_pixel(p);
	endtask

	// drop valid and let every expected symbol drain before touching registers
	task wait_idle();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && symbol_valid && symbol_ready)
			sb.check(symbol);
	end

	// symbol sink: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		symbol_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				gap = hold_request;
				hold_request = 0;
				symbol_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end else begin
				gap = pick_gap(receiver_idle_on);
				if (gap > 0) begin
					symbol_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			symbol_ready <= 1'b1;
			do @(posedge clk); while (!symbol_valid);
		end
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned        frame_len;
		int                 count;
		logic [CFG_W-1:0]   fa;
		sb               = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		pixel_valid      = 1'b0;
		pixel            = '0;
		sender_idle_on   = 1'b1;
		receiver_idle_on = 1'b1;
		hold_request     = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// register values straight out of reset
		send_pixel('{red_level: 8'h00, green_level: 8'h00, blue_level: 8'h00});
		send_pixel('{red_level: 8'hFF, green_level: 8'hFF, blue_level: 8'hFF});
		send_pixel('{red_level: 8'h80, green_level: 8'h01, blue_level: 8'hA5});

		// zero-length frame acts as one pixel, faulty indices equal and outside the frame
		wait_idle();
		apply_config(20'd0, 20'd1023, 20'd1023, 20'hFFFFF, 20'd0, 20'd1023, 20'd1023);
		send_pixel('{red_level: 8'hFF, green_level: 8'h00, blue_level: 8'h00});
		send_pixel('{red_level: 8'h00, green_level: 8'hFF, blue_level: 8'h00});
		send_pixel('{red_level: 8'h00, green_level: 8'h00, blue_level: 8'hFF});

		// high time longer than the period, both faulty indices on one position
		wait_idle();
		apply_config(20'd700, 20'd900, 20'd500, 20'd0, 20'd8, 20'd3, 20'd3);
		send_pixel('{red_level: 8'h5A, green_level: 8'hC3, blue_level: 8'h3C});
		send_pixel('{red_level: 8'hA5, green_level: 8'h0F, blue_level: 8'hF0});
		send_pixel('{red_level: 8'h01, green_level: 8'h80, blue_level: 8'h7E});
		send_pixel('{red_level: 8'hFF, green_level: 8'hFF, blue_level: 8'hFF});
		send_pixel('{red_level: 8'h55, green_level: 8'hAA, blue_level: 8'h99});
		send_pixel('{red_level: 8'hFE, green_level: 8'h7F, blue_level: 8'h01});

		// shrink the frame below the current position, zero period, masked and unused writes
		wait_idle();
		write_register(REG_PIXEL_CNT, 20'd2);
		write_register(REG_BIT_PERIOD, 20'd0);
		write_register(REG_UNUSED, 20'hFFFFF);
		write_register(REG_ZERO_HIGH, 20'hFFC05);
		write_register(REG_LATCH, 20'd12345);
		send_pixel('{red_level: 8'h12, green_level: 8'h34, blue_level: 8'h56});
		send_pixel('{red_level: 8'h00, green_level: 8'hFF, blue_level: 8'h81});
		send_pixel('{red_level: 8'hC0, green_level: 8'h03, blue_level: 8'h18});

		// oversized pixel count clamps to the full span
		wait_idle();
		apply_config(20'd1, 20'd2, 20'd3, 20'd77, 20'd2047, 20'd0, 20'd1023);
		send_pixel('{red_level: 8'hFF, green_level: 8'hFF, blue_level: 8'hFF});
		send_pixel('{red_level: 8'h81, green_level: 8'h42, blue_level: 8'h24});
		send_pixel('{red_level: 8'h00, green_level: 8'h00, blue_level: 8'h01});

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_register(REG_ZERO_HIGH, pick_value(1023));
			write_register(REG_ONE_HIGH, pick_value(1023));
			write_register(REG_BIT_PERIOD, pick_value(1023));
			write_register(REG_LATCH, pick_value(32'hFFFFF));
			case ($urandom_range(0, 7))
				0: write_register(REG_PIXEL_CNT, 20'd0);
				1: write_register(REG_PIXEL_CNT, 20'd1);
				2: write_register(REG_PIXEL_CNT, CFG_W'($urandom_range(2, 5)));
				3, 4: write_register(REG_PIXEL_CNT, CFG_W'($urandom_range(1, 24)));
				5: write_register(REG_PIXEL_CNT, 20'd2047);
				6: write_register(REG_PIXEL_CNT, 20'd1024);
				default: write_register(REG_PIXEL_CNT, CFG_W'($urandom_range(0, 2047)));
			endcase
			frame_len = sb.frame_length();
			fa = pick_faulty(frame_len);
			write_register(REG_FAULTY_A, fa);
			if ($urandom_range(0, 7) == 0)
				write_register(REG_FAULTY_B, fa);
			else
				write_register(REG_FAULTY_B, pick_faulty(frame_len));
			sender_idle_on   = ($urandom_range(0, 3) != 0);
			receiver_idle_on = ($urandom_range(0, 3) != 0);
			// stall the sink for a long stretch while pixels keep coming
			if (ph == 2) begin
				sender_idle_on = 1'b0;
				hold_request   = 500;
			end
			count = 48 + $urandom_range(0, 6);
			repeat (count) send_pixel(pixel_t'(24'($urandom)));
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
